[rtl/angle_frame_crc_checker_core_assert.svh]
// Assertion macros shared by the checker RTL.
// Each macro expects signals named clk and arst_n in the using scope.
`ifndef ANGLE_FRAME_CRC_CHECKER_CORE_ASSERT_SVH
`define ANGLE_FRAME_CRC_CHECKER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define AFCC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define AFCC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/afcc_pkg.sv]
package afcc_pkg;

	localparam int CHECKED_BYTES = 4;

	localparam logic [7:0]  CRC_POLY    = 8'h1D;
	localparam logic [7:0]  CRC_SEED    = 8'hFF;
	localparam logic [2:0]  FRAME_LAST  = 3'd5;
	localparam logic [2:0]  POS_DATA_HI = 3'd2;
	localparam logic [2:0]  POS_DATA_LO = 3'd3;
	localparam logic [15:0] ANGLE_MASK  = 16'h7FFF;
	localparam logic [3:0]  RETRY_RESET = 4'd3;
	localparam logic [3:0]  FAIL_MAX    = 4'hF;
	localparam logic [15:0] ERR_MAX     = 16'hFFFF;

	// Frame tracker status toward the top level
	typedef struct packed {
		logic        last;
		logic        ok;
		logic [14:0] angle;
	} frm_t;

	// One byte of CRC-8, MSB first
	function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] v;
		v = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (v[7]) begin
				v = {v[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				v = {v[6:0], 1'b0};
			end
		end
		return v;
	endfunction

endpackage

[rtl/afcc_frame_track.sv]
module afcc_frame_track
	import afcc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	input  logic       first_of_frame,
	output frm_t       frm
);

	logic [7:0]  crc_q;
	logic [2:0]  pos_q;
	logic [15:0] data_q;

	logic [7:0]  crc_base;
	logic [2:0]  pos;
	logic [7:0]  crc_next;
	logic [15:0] data_next;

	// Restart position and CRC on a frame mark
	always_comb begin
		crc_base = first_of_frame ? CRC_SEED : crc_q;
		pos      = first_of_frame ? 3'd0 : pos_q;
		crc_next = (32'(pos) < CHECKED_BYTES) ? crc_byte(crc_base, rx_byte) : crc_base;
		data_next = data_q;
		if (pos == POS_DATA_HI) begin
			data_next = {rx_byte, data_q[7:0]};
		end else if (pos == POS_DATA_LO) begin
			data_next = {data_q[15:8], rx_byte};
		end
	end

	// Compare inverted CRC with the low safety byte at frame end
	always_comb begin
		frm.last  = (pos == FRAME_LAST);
		frm.ok    = (~crc_next == rx_byte);
		frm.angle = frm.ok ? data_next[14:0] & ANGLE_MASK[14:0] : 15'd0;
	end

	// Advance frame state on each processed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= CRC_SEED;
			pos_q  <= 3'd0;
			data_q <= 16'd0;
		end else if (step) begin
			data_q <= data_next;
			if (frm.last) begin
				crc_q <= CRC_SEED;
				pos_q <= 3'd0;
			end else begin
				crc_q <= crc_next;
				pos_q <= pos + 3'd1;
			end
		end
	end

endmodule

[rtl/angle_frame_crc_checker_core.sv]
// Channel | Direction | Handshake                  | Payload
// in      | input     | in_valid / in_stall        | rx_byte, first_of_frame, new_request
// out     | output    | out_valid / out_stall      | frame_ok, angle_raw, retry_needed,
//         |           |                            | request_failed, error_total
// cfg     | input     | cfg_valid / cfg_ready      | cfg_data (retry_limit)
//
// One byte per cycle sustained while in_stall is low; each byte is registered in
// stage 1, then the CRC update and compare run combinationally into the result
// register, so the result is registered once the sixth byte of a frame leaves stage 1.
// A result appears at the sixth byte of each frame only.
// Reset clears CRC (to seed), position, data word, counters and retry_limit (3).
// out_stall backs up into in_stall only when a frame-end byte finds the result
// register still occupied; cfg_ready is always high.
`include "angle_frame_crc_checker_core_assert.svh"

module angle_frame_crc_checker_core
	import afcc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        first_of_frame,
	input  logic        new_request,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        frame_ok,
	output logic [14:0] angle_raw,
	output logic        retry_needed,
	output logic        request_failed,
	output logic [15:0] error_total,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data
);

	logic        v_s1;
	logic [7:0]  byte_s1;
	logic        first_s1;
	logic        newreq_s1;

	logic [3:0]  retry_limit_q;
	logic [3:0]  fail_q;
	logic [15:0] err_q;

	frm_t        frm;
	logic        adv;
	logic        step;
	logic        in_fire;
	logic [3:0]  fail_base;
	logic [3:0]  fail_inc;
	logic [15:0] err_inc;

	assign cfg_ready = 1'b1;

	// Byte in stage 1 moves on unless it needs a busy result register
	assign adv      = !frm.last || !out_valid || !out_stall;
	assign step     = v_s1 && adv;
	assign in_stall = v_s1 && !adv;
	assign in_fire  = in_valid && !in_stall;

	// Capture the input transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_fire) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1   <= rx_byte;
			first_s1  <= first_of_frame;
			newreq_s1 <= new_request;
		end
	end

	afcc_frame_track u_track (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.rx_byte        (byte_s1),
		.first_of_frame (first_s1),
		.frm            (frm)
	);

	// Saturating failure counts
	always_comb begin
		fail_base = newreq_s1 ? 4'd0 : fail_q;
		fail_inc  = (fail_base == FAIL_MAX) ? FAIL_MAX : fail_base + 4'd1;
		err_inc   = (err_q == ERR_MAX) ? ERR_MAX : err_q + 16'd1;
	end

	// Hold the retry limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q <= RETRY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			retry_limit_q <= cfg_data;
		end
	end

	// Update failure counters per processed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_q <= 4'd0;
			err_q  <= 16'd0;
		end else if (step) begin
			if (!frm.last) begin
				fail_q <= fail_base;
			end else if (frm.ok) begin
				fail_q <= 4'd0;
			end else begin
				fail_q <= fail_inc;
				err_q  <= err_inc;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (step && frm.last) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && frm.last) begin
			frame_ok       <= frm.ok;
			angle_raw      <= frm.angle;
			retry_needed   <= !frm.ok && (fail_inc < retry_limit_q);
			request_failed <= !frm.ok && (fail_inc >= retry_limit_q);
			error_total    <= frm.ok ? err_q : err_inc;
		end
	end

	`AFCC_ASSERT_IMP(a_flags_excl, out_valid,
		!(retry_needed && request_failed) && !(frame_ok && (retry_needed || request_failed)),
		"result flags overlap")
	`AFCC_ASSERT_IMP(a_err_step, err_q != $past(err_q), err_q == $past(err_q) + 16'd1,
		"error count moved by other than one")
	`AFCC_ASSERT_IMP(a_stall_src, in_stall, v_s1 && out_valid && out_stall,
		"input stalled without a blocked result")
	`AFCC_ASSERT_NXT(a_s1_hold, v_s1 && !adv, v_s1 && $stable(byte_s1),
		"stage 1 byte lost while blocked")

endmodule

[dv/tb_angle_frame_crc_checker_core.sv]
`timescale 1ns / 1ps

module tb_angle_frame_crc_checker_core;
	import afcc_pkg::*;

	localparam int SETTLE_CYCLES = 6;
	localparam int IDLE_LIMIT    = 2000;
	localparam int HOLD_CYCLES   = 300;
	localparam int PHASE_BYTES   = 60;
	localparam int PRINT_CAP     = 40;

	// One frame verdict as seen on the result channel
	typedef struct packed {
		logic        ok;
		logic [14:0] angle;
		logic        retry;
		logic        failed;
		logic [15:0] errors;
	} frame_verdict_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  rx_byte;
	logic        first_of_frame;
	logic        new_request;
	logic        out_valid;
	logic        out_stall;
	logic        frame_ok;
	logic [14:0] angle_raw;
	logic        retry_needed;
	logic        request_failed;
	logic [15:0] error_total;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [3:0]  cfg_data;

	// Frame tracker mirror
	logic [7:0]  crc_acc;
	logic [2:0]  byte_pos;
	logic [15:0] data_mirror;
	logic [3:0]  fail_run;
	logic [15:0] err_cnt;
	logic [3:0]  retry_lim;

	frame_verdict_t expected_verdicts[$];

	int src_idle_pct  = 0;
	int sink_stall_pct = 0;
	int hold_request  = 0;
	int hold_left     = 0;
	int idle_cycles   = 0;
	int mismatch_count = 0;
	int bytes_sent    = 0;
	int verdicts_seen = 0;
	int crc_pass_seen = 0;
	int crc_fail_seen = 0;

	angle_frame_crc_checker_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.first_of_frame(first_of_frame),
		.new_request   (new_request),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.frame_ok      (frame_ok),
		.angle_raw     (angle_raw),
		.retry_needed  (retry_needed),
		.request_failed(request_failed),
		.error_total   (error_total),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// CRC-8 over one byte, MSB first
	function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] v;
		v = acc ^ b;
		repeat (8) v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
		return v;
	endfunction

	// Advance the mirror by one accepted byte; queue a verdict at frame end
	function automatic void track_frame_byte(input logic [7:0] b, input logic mark,
			input logic newreq);
		logic [2:0]     p;
		frame_verdict_t v;
		if (newreq)
			fail_run = '0;
		if (mark) begin
			byte_pos = '0;
			crc_acc  = CRC_SEED;
		end
		p = byte_pos;
		if (32'(p) < CHECKED_BYTES)
			crc_acc = crc8_step(crc_acc, b);
		if (p == 3'd2)
			data_mirror[15:8] = b;
		else if (p == 3'd3)
			data_mirror[7:0] = b;
		if (p < FRAME_LAST) begin
			byte_pos = p + 3'd1;
			return;
		end
		v    = '0;
		v.ok = (~crc_acc == b);
		if (v.ok) begin
			v.angle  = data_mirror[14:0];
			fail_run = '0;
		end else begin
			if (err_cnt != ERR_MAX)
				err_cnt = err_cnt + 16'd1;
			if (fail_run != FAIL_MAX)
				fail_run = fail_run + 4'd1;
			if (fail_run >= retry_lim)
				v.failed = 1'b1;
			else
				v.retry = 1'b1;
		end
		v.errors = err_cnt;
		expected_verdicts.push_back(v);
		byte_pos = '0;
		crc_acc  = CRC_SEED;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("MISMATCH at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
	endtask

	// Offer one byte, with random idle cycles ahead of it, and hold until taken
	task automatic send_byte(input logic [7:0] b, input logic mark, input logic newreq);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		rx_byte        <= b;
		first_of_frame <= mark;
		new_request    <= newreq;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		bytes_sent++;
		track_frame_byte(b, mark, newreq);
	endtask

	// Send a full six-byte frame; a bad one carries a corrupted low safety byte
	task automatic send_frame(input logic [15:0] cmd, input logic [15:0] data,
			input logic good, input logic mark, input logic newreq);
		logic [7:0] crc;
		logic [7:0] safety_lo;
		crc = crc8_step(CRC_SEED, cmd[15:8]);
		crc = crc8_step(crc, cmd[7:0]);
		crc = crc8_step(crc, data[15:8]);
		crc = crc8_step(crc, data[7:0]);
		safety_lo = ~crc;
		if (!good)
			safety_lo = safety_lo ^ 8'($urandom_range(1, 255));
		send_byte(cmd[15:8], mark, newreq);
		send_byte(cmd[7:0], 1'b0, 1'b0);
		send_byte(data[15:8], 1'b0, 1'b0);
		send_byte(data[7:0], 1'b0, 1'b0);
		send_byte(8'($urandom), 1'b0, 1'b0);
		send_byte(safety_lo, 1'b0, 1'b0);
	endtask

	// Drop valid and wait for every pending verdict, then let the pipe settle
	task automatic drain_verdicts();
		in_valid <= 1'b0;
		while (expected_verdicts.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_retry_limit(input logic [3:0] lim);
		drain_verdicts();
		cfg_valid <= 1'b1;
		cfg_data  <= lim;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		retry_lim = lim;
	endtask

	// Field extremes, unmarked follow-on frame, mid-frame restart
	task automatic test_directed_frames();
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		send_frame(16'h0000, 16'h0000, 1'b1, 1'b1, 1'b1);
		send_frame(16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0);
		send_frame(16'h8021, 16'h8000, 1'b0, 1'b1, 1'b0);
		send_byte(8'hFF, 1'b1, 1'b0);
		send_byte(8'h00, 1'b0, 1'b1);
		send_byte(8'hA5, 1'b0, 1'b0);
		send_frame(16'h8021, 16'h7FFF, 1'b1, 1'b1, 1'b0);
	endtask

	// Failure runs at each limit extreme, past the saturation of the run count
	task automatic test_retry_limits();
		logic [3:0] limits[4];
		limits = '{4'd0, 4'd1, 4'd15, 4'd3};
		src_idle_pct   = 20;
		sink_stall_pct = 20;
		foreach (limits[i]) begin
			write_retry_limit(limits[i]);
			send_frame(16'($urandom), 16'($urandom), 1'b0, 1'b1, 1'b1);
			repeat (int'(limits[i]) + 1)
				send_frame(16'($urandom), 16'($urandom), 1'b0, 1'b1, 1'b0);
			send_frame(16'($urandom), 16'($urandom), 1'b1, 1'b1, 1'b0);
			send_frame(16'($urandom), 16'($urandom), 1'b0, 1'b0, 1'b0);
		end
	endtask

	// Mostly well-formed frames with random content, some truncated frames and noise
	task automatic random_phase(input int src_pct, input int sink_pct);
		int start;
		int sel;
		int n;
		write_retry_limit(4'($urandom_range(15)));
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
		start = bytes_sent;
		while (bytes_sent - start < PHASE_BYTES) begin
			sel = $urandom_range(99);
			if (sel < 80) begin
				send_frame(16'($urandom), 16'($urandom), $urandom_range(99) < 60,
					$urandom_range(99) < 75, $urandom_range(99) < 25);
			end else if (sel < 90) begin
				n = $urandom_range(1, 5);
				send_byte(8'($urandom), 1'b1, 1'($urandom_range(1)));
				repeat (n - 1) send_byte(8'($urandom), 1'b0, 1'b0);
			end else begin
				send_byte(8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)));
			end
		end
	endtask

	task automatic test_random_traffic();
		random_phase(0, 0);
		random_phase(62, 0);
		random_phase(0, 62);
		random_phase(9, 9);
	endtask

	// Hold the output long enough that the input backs up
	task automatic test_output_backpressure();
		drain_verdicts();
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		hold_request   = HOLD_CYCLES;
		repeat (10) send_frame(16'($urandom), 16'($urandom), 1'b1, 1'b1, 1'b0);
	endtask

	// Drive output stall: long hold when requested, random otherwise
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < sink_stall_pct);
		end
	end

	// Check each accepted verdict against the oldest expectation
	always @(posedge clk) begin
		frame_verdict_t want;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (expected_verdicts.size() == 0) begin
				report_mismatch("verdict with no frame pending", 1, 0);
			end else begin
				want = expected_verdicts.pop_front();
				verdicts_seen++;
				if (want.ok)
					crc_pass_seen++;
				else
					crc_fail_seen++;
				if (frame_ok !== want.ok)
					report_mismatch("frame_ok", 32'(frame_ok), 32'(want.ok));
				if (angle_raw !== want.angle)
					report_mismatch("angle_raw", 32'(angle_raw), 32'(want.angle));
				if (retry_needed !== want.retry)
					report_mismatch("retry_needed", 32'(retry_needed), 32'(want.retry));
				if (request_failed !== want.failed)
					report_mismatch("request_failed", 32'(request_failed),
						32'(want.failed));
				if (error_total !== want.errors)
					report_mismatch("error_total", 32'(error_total), 32'(want.errors));
			end
		end
	end

	// End the run when no transaction moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Watchdog: no transaction for %0d cycles", IDLE_LIMIT);
				$display("angle_frame_crc_checker_core verification failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		rx_byte        = '0;
		first_of_frame = 1'b0;
		new_request    = 1'b0;
		out_stall      = 1'b0;
		cfg_valid      = 1'b0;
		cfg_data       = '0;
		crc_acc        = CRC_SEED;
		byte_pos       = '0;
		data_mirror    = '0;
		fail_run       = '0;
		err_cnt        = '0;
		retry_lim      = RETRY_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_frames();
		test_retry_limits();
		test_random_traffic();
		test_output_backpressure();
		drain_verdicts();

		$display("Covered %0d bytes and %0d frame verdicts (%0d CRC pass, %0d CRC fail)",
			bytes_sent, verdicts_seen, crc_pass_seen, crc_fail_seen);
		$display("Retry limits 0, 1, 3, 15 and random; %0d-cycle output hold",
			HOLD_CYCLES);
		if (mismatch_count == 0 && expected_verdicts.size() == 0)
			$display("angle_frame_crc_checker_core verification clean");
		else
			$display("angle_frame_crc_checker_core verification failed");
		$finish;
	end

endmodule
